>>> src/htw_pkg.sv
// Shared types and constants for the hierarchical timer wheel.
package htw_pkg;

    localparam int unsigned WHEEL = 60;

    typedef enum logic [2:0] {
        K_ADD_OK    = 3'd0,
        K_SLOT_FULL = 3'd1,
        K_TOO_FAR   = 3'd2,
        K_FIRED     = 3'd3,
        K_DROP      = 3'd4
    } t_kind;

    typedef struct packed {
        logic        mode;
        logic [15:0] task_id;
        logic [11:0] delay;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] task_id_res;
        logic [31:0] done_count;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_CALC,
        S_ADD_DIV,
        S_ADD_SLOT,
        S_ADD_WR,
        S_FIRE_RD,
        S_FIRE_CNT,
        S_FIRE_ENT,
        S_FIRE_EMIT,
        S_CAS_RD,
        S_CAS_CNT,
        S_CAS_ENT,
        S_CAS_OFF,
        S_CAS_PUT,
        S_FINISH
    } t_state;

endpackage

>>> src/htw_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/hierarchical_timer_wheel_top.sv
// Top level of the two-level timer wheel: sequencer, fill and entry memories.
//
// Usage: raise i_start with a request on i_req; it is taken at a rising edge
// with o_busy low. Mode 0 adds a task, mode 1 advances time by one tick.
// Results appear on o_res for one cycle each, flagged by o_valid; o_res.last
// marks the final result of a request. The receiver cannot hold results off.
// Each result is held in a pending register until the next one or the end of
// the request is known, so that last can be set on the final one.
// An add steps through ADD_CALC, ADD_DIV, ADD_SLOT and ADD_WR and gives its
// one result in FINISH. A tick reads the current second slot's fill count and
// fires each of its entries; on a minute wrap the next minute slot is cascaded,
// each entry moved to its second slot, or dropped if that slot is full.
// Tick results come in order: fires, then cascade drops. A quiet tick gives
// none. Fill counts and entries live in memories with registered read data.
// After reset a clearing pass zeroes the fill counts with o_busy high; entry
// memories are not cleared, as only entries below a fill count are ever used.
// Reset returns the wheel to time zero, empty.
module hierarchical_timer_wheel_top
    import htw_pkg::*;
#(
    parameter int SLOT_DEPTH = 4,
    parameter int ID_WIDTH   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_valid,
    output t_res o_res
);
    localparam int FW    = $clog2(SLOT_DEPTH + 1);
    localparam int DEPTH = WHEEL * SLOT_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = ID_WIDTH + 6;

    t_state r_state, n_state;
    logic [5:0]    r_sec, n_sec, r_min, n_min;
    logic [31:0]   r_total, n_total;
    logic [ID_WIDTH-1:0] r_id;
    logic [11:0]   r_delay;
    logic [12:0]   r_sum, n_sum;
    logic [6:0]    r_q, n_q;
    logic [5:0]    r_slot, n_slot;
    logic [5:0]    r_off, n_off;
    logic          r_tomin, n_tomin;
    logic          r_far, n_far;
    logic [FW-1:0] r_cnt, n_cnt;
    logic [FW-1:0] r_i, n_i;
    logic [ID_WIDTH-1:0] r_cid, n_cid;
    logic [5:0]    r_clr, n_clr;
    logic          r_pvalid, n_pvalid;
    t_res          r_pend, n_pend;
    logic          res_new;
    t_res          res_val;

    // entry and fill memories
    logic          se_we, me_we, sf_we, mf_we;
    logic [AW-1:0] se_wa, se_ra, me_wa, me_ra;
    logic [ID_WIDTH-1:0] se_wd, se_rd;
    logic [MW-1:0] me_wd, me_rd;
    logic [5:0]    sf_wa, sf_ra, mf_wa, mf_ra;
    logic [FW-1:0] sf_wd, sf_rd, mf_wd, mf_rd;

    htw_ram #(.WIDTH(ID_WIDTH), .DEPTH(DEPTH)) u_sec (
        .i_clk(i_clk), .i_we(se_we), .i_waddr(se_wa), .i_wdata(se_wd),
        .i_raddr(se_ra), .o_rdata(se_rd));
    htw_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_min (
        .i_clk(i_clk), .i_we(me_we), .i_waddr(me_wa), .i_wdata(me_wd),
        .i_raddr(me_ra), .o_rdata(me_rd));
    htw_ram #(.WIDTH(FW), .DEPTH(WHEEL)) u_sfill (
        .i_clk(i_clk), .i_we(sf_we), .i_waddr(sf_wa), .i_wdata(sf_wd),
        .i_raddr(sf_ra), .o_rdata(sf_rd));
    htw_ram #(.WIDTH(FW), .DEPTH(WHEEL)) u_mfill (
        .i_clk(i_clk), .i_we(mf_we), .i_waddr(mf_wa), .i_wdata(mf_wd),
        .i_raddr(mf_ra), .o_rdata(mf_rd));

    function automatic logic [AW-1:0] addr(input logic [5:0] slot,
                                           input logic [FW-1:0] idx);
        return AW'(slot) * AW'(SLOT_DEPTH) + AW'(idx);
    endfunction

    // add placement: quotient by reciprocal, then one correction step
    logic [12:0] sum_s;
    logic [23:0] prod;
    logic [12:0] rem;
    logic [6:0]  q_fix;
    logic [5:0]  off_fix;
    logic [7:0]  emin_t;
    logic [5:0]  emin_slot;
    logic [5:0]  mnext;
    logic [5:0]  m_off_raw;
    logic [5:0]  cas_off;
    always_comb begin
        sum_s = 13'(r_sec) + 13'(r_delay);
        prod  = 24'(sum_s) * 24'd1092;
        rem   = r_sum - 13'(r_q) * 13'd60;
        if (rem >= 13'd60) begin
            q_fix   = r_q + 7'd1;
            off_fix = 6'(rem - 13'd60);
        end else begin
            q_fix   = r_q;
            off_fix = 6'(rem);
        end
        emin_t = 8'(r_min) + 8'(r_q);
        if (emin_t >= 8'd120) emin_slot = 6'(emin_t - 8'd120);
        else if (emin_t >= 8'd60) emin_slot = 6'(emin_t - 8'd60);
        else emin_slot = 6'(emin_t);
        mnext = (r_min == 6'd59) ? 6'd0 : r_min + 6'd1;
        m_off_raw = me_rd[MW-1:ID_WIDTH];
        cas_off = (m_off_raw >= 6'd60) ? m_off_raw - 6'd60 : m_off_raw;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_sec = r_sec; n_min = r_min; n_total = r_total;
        n_sum = r_sum; n_q = r_q; n_slot = r_slot; n_off = r_off;
        n_tomin = r_tomin; n_far = r_far; n_cnt = r_cnt; n_i = r_i;
        n_cid = r_cid; n_clr = r_clr; n_pvalid = r_pvalid; n_pend = r_pend;
        res_new = 1'b0;
        res_val.kind = K_ADD_OK;
        res_val.task_id_res = 16'(r_id);
        res_val.done_count = r_total;
        res_val.last = 1'b0;
        se_we = 1'b0; se_wa = addr(r_slot, sf_rd); se_wd = r_id;
        se_ra = addr(r_sec, r_i);
        me_we = 1'b0; me_wa = addr(r_slot, mf_rd); me_wd = {r_off, r_id};
        me_ra = addr(mnext, r_i);
        sf_we = 1'b0; sf_wa = r_slot; sf_wd = sf_rd + FW'(1); sf_ra = r_sec;
        mf_we = 1'b0; mf_wa = r_slot; mf_wd = mf_rd + FW'(1); mf_ra = mnext;
        o_valid = 1'b0;
        o_res = r_pend;
        o_res.last = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                sf_we = 1'b1; sf_wa = r_clr; sf_wd = '0;
                mf_we = 1'b1; mf_wa = r_clr; mf_wd = '0;
                if (r_clr == 6'd59) begin
                    n_clr = '0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 6'd1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_i = '0;
                    n_state = i_req.mode ? S_FIRE_RD : S_ADD_CALC;
                end
            end
            S_ADD_CALC: begin
                n_sum = sum_s;
                n_q = 7'(prod >> 16);
                n_state = S_ADD_DIV;
            end
            S_ADD_DIV: begin
                n_q = q_fix;
                n_off = off_fix;
                n_state = S_ADD_SLOT;
            end
            S_ADD_SLOT: begin
                if (r_delay < 12'd60) begin
                    n_tomin = 1'b0;
                    n_far = 1'b0;
                    n_slot = r_off;
                end else begin
                    n_tomin = 1'b1;
                    n_far = (r_q >= 7'd60);
                    n_slot = emin_slot;
                end
                sf_ra = n_slot;
                mf_ra = n_slot;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                res_new = 1'b1;
                if (r_far) begin
                    res_val.kind = K_TOO_FAR;
                end else if (!r_tomin) begin
                    if (sf_rd >= FW'(SLOT_DEPTH)) res_val.kind = K_SLOT_FULL;
                    else begin
                        se_we = 1'b1; sf_we = 1'b1;
                    end
                end else begin
                    if (mf_rd >= FW'(SLOT_DEPTH)) res_val.kind = K_SLOT_FULL;
                    else begin
                        me_we = 1'b1; mf_we = 1'b1;
                    end
                end
                n_state = S_FINISH;
            end
            S_FIRE_RD: begin
                n_state = S_FIRE_CNT;
            end
            S_FIRE_CNT: begin
                n_cnt = sf_rd;
                n_i = '0;
                sf_we = 1'b1; sf_wa = r_sec; sf_wd = '0;
                n_state = S_FIRE_ENT;
            end
            S_FIRE_ENT: begin
                if (r_i < r_cnt) begin
                    n_state = S_FIRE_EMIT;
                end else begin
                    n_i = '0;
                    if (r_sec == 6'd59) begin
                        n_sec = 6'd0;
                        n_state = S_CAS_RD;
                    end else begin
                        n_sec = r_sec + 6'd1;
                        n_state = S_FINISH;
                    end
                end
            end
            S_FIRE_EMIT: begin
                res_new = 1'b1;
                res_val.kind = K_FIRED;
                res_val.task_id_res = 16'(se_rd);
                res_val.done_count = r_total + 32'd1;
                n_total = r_total + 32'd1;
                n_i = r_i + FW'(1);
                n_state = S_FIRE_ENT;
            end
            S_CAS_RD: begin
                n_state = S_CAS_CNT;
            end
            S_CAS_CNT: begin
                n_cnt = mf_rd;
                n_i = '0;
                mf_we = 1'b1; mf_wa = mnext; mf_wd = '0;
                n_state = S_CAS_ENT;
            end
            S_CAS_ENT: begin
                if (r_i < r_cnt) begin
                    n_state = S_CAS_OFF;
                end else begin
                    n_min = mnext;
                    n_state = S_FINISH;
                end
            end
            S_CAS_OFF: begin
                n_off = cas_off;
                n_cid = me_rd[ID_WIDTH-1:0];
                sf_ra = cas_off;
                n_state = S_CAS_PUT;
            end
            S_CAS_PUT: begin
                n_i = r_i + FW'(1);
                n_state = S_CAS_ENT;
                if (sf_rd >= FW'(SLOT_DEPTH)) begin
                    res_new = 1'b1;
                    res_val.kind = K_DROP;
                    res_val.task_id_res = 16'(r_cid);
                end else begin
                    se_we = 1'b1;
                    se_wa = addr(r_off, sf_rd);
                    se_wd = r_cid;
                    sf_we = 1'b1; sf_wa = r_off;
                end
            end
            S_FINISH: begin
                if (r_pvalid) begin
                    o_valid = 1'b1;
                    o_res.last = 1'b1;
                end
                n_pvalid = 1'b0;
                n_state = S_IDLE;
            end
        endcase
        // a new result pushes the pending one out, not last
        if (res_new) begin
            if (r_pvalid) o_valid = 1'b1;
            n_pvalid = 1'b1;
            n_pend = res_val;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_sec <= '0; r_min <= '0; r_total <= '0;
            r_clr <= '0; r_pvalid <= 1'b0; r_i <= '0;
        end else begin
            r_state <= n_state; r_sec <= n_sec; r_min <= n_min;
            r_total <= n_total; r_clr <= n_clr; r_pvalid <= n_pvalid;
            r_i <= n_i;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_id <= ID_WIDTH'(i_req.task_id);
            r_delay <= i_req.delay;
        end
        r_sum <= n_sum; r_q <= n_q; r_slot <= n_slot; r_off <= n_off;
        r_tomin <= n_tomin; r_far <= n_far; r_cnt <= n_cnt; r_cid <= n_cid;
        r_pend <= n_pend;
    end

    // checks
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid) else $error("result while idle");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> (r_state == S_FINISH))
        else $error("last before end of request");
    a_fire_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRE_EMIT) |=> (r_total == $past(r_total) + 32'd1))
        else $error("fire count slip");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |-> (sf_rd <= FW'(SLOT_DEPTH) && mf_rd <= FW'(SLOT_DEPTH)))
        else $error("fill count out of range");
endmodule
